[hdl/hnm_pkg.sv]
package hnm_pkg;

   localparam int HEIGHT_W = 8;
   localparam int SCALE_W  = 16;
   localparam int ROW_W    = 16;
   localparam int OUT_COL_W = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DATA_W  = 56;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RELIEF_SCALE = 2'd2;

   localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd256;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd256;
   localparam logic [15:0] RELIEF_SCALE_RESET = 16'd16384;

   // Square of the z numerator 255*256 and the square of 255.
   localparam logic [47:0] K_SQUARED   = 48'd4261478400;
   localparam logic [15:0] BYTE_SQUARE = 16'd65025;

   localparam logic [1:0] JOB_UPPER       = 2'd0;
   localparam logic [1:0] JOB_BOTTOM_LEFT = 2'd1;
   localparam logic [1:0] JOB_BOTTOM_END  = 2'd2;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   localparam logic [2:0] ITER_LAST = 3'd7;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD0,
      OP_RD1,
      OP_RD2,
      OP_PREP,
      OP_SQR,
      OP_SUM,
      OP_WLO,
      OP_WHI,
      OP_TSQ,
      OP_MLO,
      OP_MHI,
      OP_STEP,
      OP_LOAD,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] job;
      logic [1:0] comp;
   } cmd_type;

   typedef struct packed {
      logic [2:0] job_en;
   } status_type;

endpackage

[hdl/height_to_normal_map_top.sv]
// Channel   Direction  Content
// req_      in         tdata: height_sample[7:0]
// rsp_      out        tdata: normal x, y, z bytes, column, row; tlast: run_last;
//                      tuser: frame_end
// csr_      in         write enable, index, 16-bit data
//
// Each item produces zero to three results; the next item is accepted only once it is done.
// Each result runs three 8-step binary searches through one shared 16x25 multiplier.
// Reset is synchronous and restores the default frame geometry and scale.
// A result waits in the output register; the next result stalls until it is taken.
module height_to_normal_map_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // height_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // normal_x_byte, normal_y_byte, normal_z_byte, out_column, out_row, zero pad
   output logic [hnm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,   // frame_end
   input  logic                                csr_we,
   input  logic [hnm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hnm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import hnm_pkg::*;

   cmd_type    cmd;
   status_type status;

   hnm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hnm_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

[hdl/hnm_ram.sv]
module hnm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/hnm_ctrl.sv]
module hnm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  hnm_pkg::status_type  status,
   output hnm_pkg::cmd_type     cmd
);
   import hnm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_JOB,
      ST_PREP,
      ST_SQR,
      ST_SUM,
      ST_WLO,
      ST_WHI,
      ST_TSQ,
      ST_MLO,
      ST_MHI,
      ST_STEP,
      ST_EMIT,
      ST_FIN
   } state_type;

   state_type  state_ff;
   logic [1:0] job_ff;
   logic [1:0] comp_ff;
   logic [2:0] iter_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_valid_in = ((state_ff == ST_EMIT) && out_free) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_UPPER;
         comp_ff      <= COMP_X;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  job_ff   <= JOB_UPPER;
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: state_ff <= ST_RD1;
            ST_RD1: state_ff <= ST_RD2;
            ST_RD2: state_ff <= ST_JOB;
            ST_JOB: begin
               if (status.job_en[job_ff]) begin
                  state_ff <= ST_PREP;
               end else if (job_ff == JOB_BOTTOM_END) begin
                  state_ff <= ST_FIN;
               end else begin
                  job_ff <= job_ff + 2'd1;
               end
            end
            ST_PREP: state_ff <= ST_SQR;
            ST_SQR:  state_ff <= ST_SUM;
            ST_SUM: begin
               comp_ff  <= COMP_X;
               state_ff <= ST_WLO;
            end
            ST_WLO: state_ff <= ST_WHI;
            ST_WHI: begin
               iter_ff  <= '0;
               state_ff <= ST_TSQ;
            end
            ST_TSQ: state_ff <= ST_MLO;
            ST_MLO: state_ff <= ST_MHI;
            ST_MHI: state_ff <= ST_STEP;
            ST_STEP: begin
               if (iter_ff == ITER_LAST) begin
                  if (comp_ff == COMP_Z) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_WLO;
                  end
               end else begin
                  iter_ff  <= iter_ff + 3'd1;
                  state_ff <= ST_TSQ;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  if (job_ff == JOB_BOTTOM_END) begin
                     state_ff <= ST_FIN;
                  end else begin
                     job_ff   <= job_ff + 2'd1;
                     state_ff <= ST_JOB;
                  end
               end
            end
            ST_FIN: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.job  = job_ff;
      cmd.comp = comp_ff;
      unique case (state_ff)
         ST_IDLE: cmd.op = req_tvalid ? OP_ACCEPT : OP_NONE;
         ST_RD0:  cmd.op = OP_RD0;
         ST_RD1:  cmd.op = OP_RD1;
         ST_RD2:  cmd.op = OP_RD2;
         ST_PREP: cmd.op = OP_PREP;
         ST_SQR:  cmd.op = OP_SQR;
         ST_SUM:  cmd.op = OP_SUM;
         ST_WLO:  cmd.op = OP_WLO;
         ST_WHI:  cmd.op = OP_WHI;
         ST_TSQ:  cmd.op = OP_TSQ;
         ST_MLO:  cmd.op = OP_MLO;
         ST_MHI:  cmd.op = OP_MHI;
         ST_STEP: cmd.op = OP_STEP;
         ST_EMIT: cmd.op = out_free ? OP_LOAD : OP_NONE;
         ST_FIN:  cmd.op = OP_FIN;
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

[hdl/hnm_dp.sv]
module hnm_dp #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hnm_pkg::cmd_type                       cmd,
   output hnm_pkg::status_type                    status,
   input  logic [7:0]                             req_tdata,
   output logic [hnm_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [hnm_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [hnm_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import hnm_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [10:0] fw_ff;
   logic [15:0] fh_ff;
   logic [15:0] scale_ff;

   logic [CW-1:0] c_ff;
   logic [15:0]   r_ff;
   logic [7:0]    s_ff, cur_head_ff, prev_head_ff, held_ff;
   logic [7:0]    center_ff, right_raw_ff, down_b_ff, down_c_ff;

   logic [23:0] ax_ff, ay_ff;
   logic        dx_pos_ff, dy_neg_ff, neg_ff, t_neg_ff;
   logic [47:0] px2_ff, qy2_ff;
   logic [49:0] l2_ff;
   logic [65:0] wv_ff, acc_ff;
   logic [7:0]  lo_ff, hi_ff, mid_ff;
   logic [15:0] t2_ff;
   logic [7:0]  bx_ff, by_ff, bz_ff;

   logic [7:0]  ox_ff, oy_ff, oz_ff;
   logic [9:0]  ocol_ff;
   logic [15:0] orow_ff;
   logic        olast_ff, oend_ff;

   logic [14:0]   w15, last_col15;
   logic [15:0]   h_eff, last_row;
   logic          c_last, r_last, c_zero;
   logic [CW-1:0] prev_raddr, first_raddr;
   logic [7:0]    prev_rdata, first_rdata;
   logic          first_we, prev_we;

   logic [7:0]  op_center, op_right, op_down;
   logic [7:0]  adx, ady;
   logic [47:0] v2_sel;
   logic        neg_sel;
   logic [15:0] mul_a;
   logic [24:0] mul_b;
   logic [40:0] mul_p;
   logic [8:0]  mid_sum;
   logic [7:0]  mid_new, t_mag;
   logic        step_ok;
   logic [7:0]  step_byte;
   logic [1:0]  last_job;
   logic [13:0] col14, col_prev14;

   always_comb begin
      if (fw_ff == '0) begin
         w15 = 15'd1;
      end else if (15'(fw_ff) > 15'(MAX_WIDTH)) begin
         w15 = 15'(MAX_WIDTH);
      end else begin
         w15 = 15'(fw_ff);
      end
   end

   assign last_col15 = w15 - 15'd1;
   assign h_eff      = (fh_ff == '0) ? 16'd1 : fh_ff;
   assign last_row   = h_eff - 16'd1;
   assign c_last     = (15'(c_ff) == last_col15);
   assign r_last     = (r_ff == last_row);
   assign c_zero     = (c_ff == '0);

   assign status.job_en = {r_last && c_last, r_last && !c_zero, r_ff != '0};
   assign last_job = status.job_en[2] ? JOB_BOTTOM_END :
                     (status.job_en[1] ? JOB_BOTTOM_LEFT : JOB_UPPER);

   assign prev_raddr  = (cmd.op == OP_RD1) ? c_ff + CW'(1) : c_ff;
   assign first_raddr = (cmd.op == OP_RD1) ? c_ff : c_ff - CW'(1);
   assign first_we    = (cmd.op == OP_ACCEPT) && (r_ff == '0);
   assign prev_we     = (cmd.op == OP_FIN);

   hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_first_row (
      .clock (clock),
      .we    (first_we),
      .waddr (c_ff),
      .wdata (req_tdata),
      .raddr (first_raddr),
      .rdata (first_rdata)
   );

   hnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev_row (
      .clock (clock),
      .we    (prev_we),
      .waddr (c_ff),
      .wdata (s_ff),
      .raddr (prev_raddr),
      .rdata (prev_rdata)
   );

   always_comb begin
      unique case (cmd.job)
         JOB_BOTTOM_LEFT: begin
            op_center = held_ff;
            op_right  = s_ff;
            op_down   = down_b_ff;
         end
         JOB_BOTTOM_END: begin
            op_center = s_ff;
            op_right  = cur_head_ff;
            op_down   = down_c_ff;
         end
         default: begin
            op_center = center_ff;
            if (!c_last) begin
               op_right = right_raw_ff;
            end else if (c_zero) begin
               op_right = center_ff;
            end else begin
               op_right = prev_head_ff;
            end
            op_down = s_ff;
         end
      endcase
   end

   assign adx = (op_right > op_center) ? op_right - op_center : op_center - op_right;
   assign ady = (op_down > op_center) ? op_down - op_center : op_center - op_down;

   always_comb begin
      unique case (cmd.comp)
         COMP_X: begin
            v2_sel  = px2_ff;
            neg_sel = dx_pos_ff;
         end
         COMP_Y: begin
            v2_sel  = qy2_ff;
            neg_sel = dy_neg_ff;
         end
         default: begin
            v2_sel  = K_SQUARED;
            neg_sel = 1'b0;
         end
      endcase
   end

   always_comb begin
      unique case (cmd.op)
         OP_WLO: begin
            mul_a = BYTE_SQUARE;
            mul_b = v2_sel[24:0];
         end
         OP_WHI: begin
            mul_a = BYTE_SQUARE;
            mul_b = {2'b00, v2_sel[47:25]};
         end
         OP_MLO: begin
            mul_a = t2_ff;
            mul_b = l2_ff[24:0];
         end
         OP_MHI: begin
            mul_a = t2_ff;
            mul_b = l2_ff[49:25];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + 9'd1;
   assign mid_new = mid_sum[8:1];
   assign t_mag   = mid_new[7] ? {mid_new[6:0], 1'b1} : {~mid_new[6:0], 1'b1};

   assign step_ok = t_neg_ff ? (!neg_ff || (acc_ff >= wv_ff)) : (!neg_ff && (acc_ff <= wv_ff));
   assign step_byte = step_ok ? mid_ff : lo_ff;

   assign col14      = 14'(c_ff);
   assign col_prev14 = 14'(c_ff - CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= FRAME_WIDTH_RESET;
         fh_ff        <= FRAME_HEIGHT_RESET;
         scale_ff     <= RELIEF_SCALE_RESET;
         c_ff         <= '0;
         r_ff         <= '0;
         cur_head_ff  <= '0;
         prev_head_ff <= '0;
         held_ff      <= '0;
      end else begin
         unique case (cmd.op)
            OP_ACCEPT: begin
               s_ff <= req_tdata;
               if (c_zero) begin
                  cur_head_ff <= req_tdata;
               end
            end
            OP_RD1: begin
               center_ff <= prev_rdata;
               down_b_ff <= first_rdata;
            end
            OP_RD2: begin
               right_raw_ff <= prev_rdata;
               down_c_ff    <= first_rdata;
            end
            OP_PREP: begin
               ax_ff     <= adx * scale_ff;
               ay_ff     <= ady * scale_ff;
               dx_pos_ff <= op_right > op_center;
               dy_neg_ff <= op_down < op_center;
            end
            OP_SQR: begin
               px2_ff <= ax_ff * ax_ff;
               qy2_ff <= ay_ff * ay_ff;
            end
            OP_SUM: begin
               l2_ff <= {2'b00, px2_ff} + {2'b00, qy2_ff} + {2'b00, K_SQUARED};
            end
            OP_WLO: begin
               acc_ff <= 66'(mul_p);
               neg_ff <= neg_sel;
               lo_ff  <= 8'd0;
               hi_ff  <= 8'd255;
            end
            OP_WHI: begin
               wv_ff <= acc_ff + {mul_p, 25'd0};
            end
            OP_TSQ: begin
               mid_ff   <= mid_new;
               t_neg_ff <= !mid_new[7];
               t2_ff    <= t_mag * t_mag;
            end
            OP_MLO: begin
               acc_ff <= 66'(mul_p);
            end
            OP_MHI: begin
               acc_ff <= acc_ff + {mul_p, 25'd0};
            end
            OP_STEP: begin
               if (step_ok) begin
                  lo_ff <= mid_ff;
               end else begin
                  hi_ff <= mid_ff - 8'd1;
               end
               unique case (cmd.comp)
                  COMP_X:  bx_ff <= step_byte;
                  COMP_Y:  by_ff <= step_byte;
                  default: bz_ff <= step_byte;
               endcase
            end
            OP_LOAD: begin
               ox_ff    <= bx_ff;
               oy_ff    <= by_ff;
               oz_ff    <= bz_ff;
               olast_ff <= (cmd.job == last_job);
               oend_ff  <= (cmd.job == last_job) && r_last && c_last;
               unique case (cmd.job)
                  JOB_BOTTOM_LEFT: begin
                     ocol_ff <= col_prev14[9:0];
                     orow_ff <= '0;
                  end
                  JOB_BOTTOM_END: begin
                     ocol_ff <= col14[9:0];
                     orow_ff <= '0;
                  end
                  default: begin
                     ocol_ff <= col14[9:0];
                     orow_ff <= h_eff - r_ff;
                  end
               endcase
            end
            OP_FIN: begin
               if (c_zero && (r_ff != '0)) begin
                  prev_head_ff <= center_ff;
               end
               if (r_last) begin
                  held_ff <= s_ff;
               end
               if (!c_last) begin
                  c_ff <= c_ff + CW'(1);
               end else begin
                  c_ff <= '0;
                  r_ff <= r_last ? '0 : r_ff + 16'd1;
               end
            end
            default: begin
            end
         endcase
         if (csr_we) begin
            unique case (csr_index)
               REG_FRAME_WIDTH: begin
                  fw_ff        <= csr_wdata[10:0];
                  c_ff         <= '0;
                  r_ff         <= '0;
                  cur_head_ff  <= '0;
                  prev_head_ff <= '0;
                  held_ff      <= '0;
               end
               REG_FRAME_HEIGHT: begin
                  fh_ff        <= csr_wdata;
                  c_ff         <= '0;
                  r_ff         <= '0;
                  cur_head_ff  <= '0;
                  prev_head_ff <= '0;
                  held_ff      <= '0;
               end
               REG_RELIEF_SCALE: begin
                  scale_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tdata = {6'd0, orow_ff, ocol_ff, oz_ff, oy_ff, ox_ff};
   assign rsp_tlast = olast_ff;
   assign rsp_tuser = oend_ff;

endmodule

[tb/height_to_normal_map_top_tb.sv]
module height_to_normal_map_top_tb;
   import hnm_pkg::*;

   localparam int MAX_W = 1024;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 400;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]  nx;
      logic [7:0]  ny;
      logic [7:0]  nz;
      logic [9:0]  column;
      logic [15:0] row;
      logic        run_last;
      logic        frame_end;
   } normal_pixel_type;

   class normal_map_scoreboard;
      logic [10:0] frame_width;
      logic [15:0] frame_height;
      logic [15:0] relief_scale;
      logic [7:0] first_row[MAX_W];
      logic [7:0] prev_row[MAX_W];
      logic [7:0] prev_head;
      logic [7:0] cur_head;
      logic [7:0] held_pixel;
      int unsigned col_count;
      int unsigned row_count;
      normal_pixel_type pending[$];
      int errors;

      function void restart_frame();
         prev_head = 0;
         cur_head = 0;
         held_pixel = 0;
         col_count = 0;
         row_count = 0;
      endfunction

      function void reset_state();
         frame_width = FRAME_WIDTH_RESET;
         frame_height = FRAME_HEIGHT_RESET;
         relief_scale = RELIEF_SCALE_RESET;
         foreach (first_row[i]) first_row[i] = 0;
         foreach (prev_row[i]) prev_row[i] = 0;
         restart_frame();
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         if (index == REG_FRAME_WIDTH) begin
            frame_width = value[10:0];
            restart_frame();
         end else if (index == REG_FRAME_HEIGHT) begin
            frame_height = value;
            restart_frame();
         end else if (index == REG_RELIEF_SCALE) begin
            relief_scale = value;
         end
      endfunction

      function bit byte_fits(int k, bit neg, logic [63:0] v2, logic [63:0] l2);
         int t;
         logic [127:0] lhs;
         logic [127:0] rhs;
         t = 2 * k - 255;
         lhs = 128'(t * t) * 128'(l2);
         rhs = 128'(65025) * 128'(v2);
         if (t < 0) return !neg || lhs >= rhs;
         return !neg && lhs <= rhs;
      endfunction

      function logic [7:0] unit_to_byte(bit neg, logic [63:0] v2, logic [63:0] l2);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = 255;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (byte_fits(mid, neg, v2, l2)) lo = mid;
            else hi = mid - 1;
         end
         return lo[7:0];
      endfunction

      function normal_pixel_type shade(int center, int right, int down, int unsigned column,
                                       int unsigned row);
         normal_pixel_type p;
         int dx;
         int dy;
         logic [63:0] ax;
         logic [63:0] ay;
         logic [63:0] px2;
         logic [63:0] qy2;
         logic [63:0] k2;
         logic [63:0] l2;
         dx = right - center;
         dy = down - center;
         ax = 64'(dx < 0 ? -dx : dx) * 64'(relief_scale);
         ay = 64'(dy < 0 ? -dy : dy) * 64'(relief_scale);
         px2 = ax * ax;
         qy2 = ay * ay;
         k2 = 64'(K_SQUARED);
         l2 = px2 + qy2 + k2;
         p.nx = unit_to_byte(dx > 0, px2, l2);
         p.ny = unit_to_byte(dy < 0, qy2, l2);
         p.nz = unit_to_byte(1'b0, k2, l2);
         p.column = column[9:0];
         p.row = row[15:0];
         p.run_last = 0;
         p.frame_end = 0;
         return p;
      endfunction

      function void note_input(logic [7:0] sample);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         int unsigned r;
         int right;
         normal_pixel_type made[$];
         normal_pixel_type p;
         w = frame_width;
         h = frame_height;
         if (w == 0) w = 1;
         if (w > MAX_W) w = MAX_W;
         if (h == 0) h = 1;
         if (col_count >= w) col_count = 0;
         if (row_count >= h) row_count = 0;
         c = col_count;
         r = row_count;
         if (r == 0) first_row[c] = sample;
         if (c == 0) cur_head = sample;
         if (r >= 1) begin
            if (c == 0) prev_head = prev_row[0];
            right = (c + 1 < w) ? prev_row[c + 1] : prev_head;
            made.push_back(shade(prev_row[c], right, sample, c, h - r));
         end
         if (r == h - 1) begin
            if (c >= 1) made.push_back(shade(held_pixel, sample, first_row[c - 1], c - 1, 0));
            if (c == w - 1) made.push_back(shade(sample, cur_head, first_row[c], c, 0));
            held_pixel = sample;
         end
         prev_row[c] = sample;
         if (made.size() > 0) begin
            p = made.pop_back();
            p.run_last = 1;
            p.frame_end = (r == h - 1 && c == w - 1);
            made.push_back(p);
         end
         foreach (made[i]) pending.push_back(made[i]);
         if (c + 1 < w) begin
            col_count = c + 1;
         end else begin
            col_count = 0;
            row_count = (r + 1 < h) ? r + 1 : 0;
         end
      endfunction

      function void check_result(normal_pixel_type got);
         normal_pixel_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("Result differs: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   normal_map_scoreboard sb = new();
   bit calm = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int sent = 0;

   always #5 clock = ~clock;

   height_to_normal_map_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      normal_pixel_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.nx = rsp_tdata[7:0];
            got.ny = rsp_tdata[15:8];
            got.nz = rsp_tdata[23:16];
            got.column = rsp_tdata[33:24];
            got.row = rsp_tdata[49:34];
            got.run_last = rsp_tlast;
            got.frame_end = rsp_tuser;
            sb.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_height(logic [7:0] value);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_input(value);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
      csr_we <= 0;
   endtask

   task automatic random_height(output logic [7:0] value);
      case ($urandom_range(0, 7))
         0: value = 8'd0;
         1: value = 8'd255;
         default: value = 8'($urandom_range(0, 255));
      endcase
   endtask

   initial begin
      logic [7:0] value;
      int n;
      logic [CSR_DATA_W-1:0] geom;
      sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Zero geometry collapses to a single pixel per frame.
      write_reg(REG_RELIEF_SCALE, 16'hffff);
      write_reg(REG_FRAME_WIDTH, 16'd0);
      write_reg(REG_FRAME_HEIGHT, 16'd0);
      for (int i = 0; i < 5; i++) send_height(i[0] ? 8'd255 : 8'd0);
      drain();

      // Oversized width saturates; a single row with zero scale.
      write_reg(REG_FRAME_WIDTH, 16'h07ff);
      write_reg(REG_FRAME_HEIGHT, 16'd1);
      write_reg(REG_RELIEF_SCALE, 16'd0);
      for (int i = 0; i < 6; i++) send_height(i[0] ? 8'd255 : 8'd0);
      drain();

      // Full 3x2 frame at maximum scale, then the start of the next frame.
      write_reg(REG_FRAME_WIDTH, 16'd3);
      write_reg(REG_FRAME_HEIGHT, 16'd2);
      write_reg(REG_RELIEF_SCALE, 16'hffff);
      write_reg(REG_UNUSED, 16'ha5a5);
      send_height(8'd0);
      send_height(8'd255);
      send_height(8'd17);
      send_height(8'd255);
      send_height(8'd0);
      send_height(8'd200);
      send_height(8'd1);
      send_height(8'd254);
      drain();

      while (sent < 380) begin
         if (sent > 320) calm = 1;
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               write_reg(REG_FRAME_WIDTH, 16'd1024);
               write_reg(REG_FRAME_HEIGHT, 16'd1);
            end else begin
               geom = 16'($urandom_range(1, 6));
               if ($urandom_range(0, 3) == 0) geom = geom | 16'hf800;
               write_reg(REG_FRAME_WIDTH, geom);
               write_reg(REG_FRAME_HEIGHT, 16'($urandom_range(1, 5)));
            end
         end
         case ($urandom_range(0, 4))
            0: write_reg(REG_RELIEF_SCALE, 16'd0);
            1: write_reg(REG_RELIEF_SCALE, 16'hffff);
            default: write_reg(REG_RELIEF_SCALE, 16'($urandom_range(0, 65535)));
         endcase
         if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
         n = $urandom_range(10, 50);
         for (int i = 0; i < n; i++) begin
            random_height(value);
            send_height(value);
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
